@@ src/b2r_pkg.sv @@
// Shared types, codes and symbol tables for the binary to Roman numeral converter.
package b2r_pkg;

   localparam logic [11:0] MAX_VALUE = 12'd3999;

   localparam logic [6:0] ASCII_I = 7'h49;
   localparam logic [6:0] ASCII_V = 7'h56;
   localparam logic [6:0] ASCII_X = 7'h58;
   localparam logic [6:0] ASCII_L = 7'h4C;
   localparam logic [6:0] ASCII_C = 7'h43;
   localparam logic [6:0] ASCII_D = 7'h44;
   localparam logic [6:0] ASCII_M = 7'h4D;

   typedef enum logic [1:0] {
      ST_CHAR  = 2'd0,
      ST_RANGE = 2'd1,
      ST_ZERO  = 2'd2
   } status_type;

   // Symbol role inside a digit pattern
   typedef enum logic [1:0] {
      SEL_ONE  = 2'd0,
      SEL_FIVE = 2'd1,
      SEL_TEN  = 2'd2
   } sel_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_THOU,
      F_HUND,
      F_TENS,
      F_PUSH
   } fst_type;

   // One classified item: digits[3] is thousands, digits[0] is ones
   typedef struct packed {
      status_type      status;
      logic [3:0][3:0] digits;
   } job_type;

   // Index of the final character in a nonzero digit's pattern
   function automatic logic [1:0] last_idx(input logic [3:0] digit);
      logic [1:0] r;
      case (digit)
         4'd2, 4'd4, 4'd6, 4'd9: r = 2'd1;
         4'd3, 4'd7:             r = 2'd2;
         4'd8:                   r = 2'd3;
         default:                r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic sel_type pattern_sel(input logic [3:0] digit, input logic [1:0] idx);
      sel_type r;
      case (digit)
         4'd4:    r = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
         4'd5:    r = SEL_FIVE;
         4'd6,
         4'd7,
         4'd8:    r = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
         4'd9:    r = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
         default: r = SEL_ONE;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] symbol_of(input logic [1:0] pos, input sel_type sel);
      logic [6:0] r;
      case ({pos, sel})
         {2'd0, SEL_ONE}:  r = ASCII_I;
         {2'd0, SEL_FIVE}: r = ASCII_V;
         {2'd0, SEL_TEN}:  r = ASCII_X;
         {2'd1, SEL_ONE}:  r = ASCII_X;
         {2'd1, SEL_FIVE}: r = ASCII_L;
         {2'd1, SEL_TEN}:  r = ASCII_C;
         {2'd2, SEL_ONE}:  r = ASCII_C;
         {2'd2, SEL_FIVE}: r = ASCII_D;
         {2'd2, SEL_TEN}:  r = ASCII_M;
         {2'd3, SEL_ONE}:  r = ASCII_M;
         default:          r = 7'd0;
      endcase
      return r;
   endfunction

   // Highest nonzero digit strictly below position lim; bit 2 flags a hit
   function automatic logic [2:0] lower_nonzero(input logic [3:0][3:0] digits,
                                                input logic [2:0] lim);
      logic [2:0] r;
      r = 3'd0;
      for (int q = 0; q < 4; q++) begin
         if ((3'(q) < lim) && (digits[q] != 4'd0)) begin
            r = {1'b1, 2'(q)};
         end
      end
      return r;
   endfunction

endpackage

@@ src/b2r_front.sv @@
// Front end: accepts a value, classifies it and splits it into decimal digits.
module b2r_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [11:0]      req_value,
   output logic             push_valid,
   input  logic             push_ready,
   output b2r_pkg::job_type push_job
);
   import b2r_pkg::*;

   fst_type     state_ff, state_in;
   logic [11:0] rem_ff, rem_in;
   job_type     job_ff, job_in;

   logic [3:0]  step_digit;
   logic [11:0] step_rem;

   // k times the power of ten that the current state works on
   function automatic logic [13:0] threshold(input fst_type st, input int k);
      logic [13:0] r;
      case (st)
         F_THOU:  r = 14'(k * 1000);
         F_HUND:  r = 14'(k * 100);
         F_TENS:  r = 14'(k * 10);
         default: r = 14'h3FFF;
      endcase
      return r;
   endfunction

   // One decimal digit per cycle: parallel compares against the nine multiples
   always_comb begin
      step_digit = 4'd0;
      step_rem   = rem_ff;
      for (int k = 1; k < 10; k++) begin
         if ({2'b00, rem_ff} >= threshold(state_ff, k)) begin
            step_digit = 4'(k);
            step_rem   = 12'({2'b00, rem_ff} - threshold(state_ff, k));
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      job_in     = job_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rem_in        = req_value;
               job_in.digits = '0;
               if (req_value > MAX_VALUE) begin
                  job_in.status = ST_RANGE;
                  state_in      = F_PUSH;
               end else if (req_value == 12'd0) begin
                  job_in.status = ST_ZERO;
                  state_in      = F_PUSH;
               end else begin
                  job_in.status = ST_CHAR;
                  state_in      = F_THOU;
               end
            end
         end
         F_THOU: begin
            job_in.digits[3] = step_digit;
            rem_in           = step_rem;
            state_in         = F_HUND;
         end
         F_HUND: begin
            job_in.digits[2] = step_digit;
            rem_in           = step_rem;
            state_in         = F_TENS;
         end
         F_TENS: begin
            job_in.digits[1] = step_digit;
            job_in.digits[0] = step_rem[3:0];
            rem_in           = step_rem;
            state_in         = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      job_ff <= job_in;
   end

endmodule

@@ src/b2r_queue.sv @@
// Small FIFO of classified items between the front end and the character emitter.
module b2r_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  b2r_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output b2r_pkg::job_type pop_job
);
   import b2r_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/b2r_back.sv @@
// Back end: walks the digits of one item and emits its characters, or its status result, into the output register.
module b2r_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  b2r_pkg::job_type pop_job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [6:0]       rsp_symbol,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);
   import b2r_pkg::*;

   logic       busy_ff, busy_in;
   job_type    job_ff, job_in;
   logic [1:0] pos_ff, pos_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_symbol_ff, rsp_symbol_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic       slot_free;
   logic [3:0] cur_digit;
   logic       digit_done;
   logic [2:0] lower;
   logic [2:0] first;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign cur_digit  = job_ff.digits[pos_ff];
   assign digit_done = (idx_ff == last_idx(cur_digit));
   assign lower      = lower_nonzero(job_ff.digits, {1'b0, pos_ff});
   assign first      = lower_nonzero(pop_job.digits, 3'd4);
   assign pop_ready  = !busy_ff;

   always_comb begin
      busy_in       = busy_ff;
      job_in        = job_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end

      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in = 1'b1;
            job_in  = pop_job;
            pos_in  = first[1:0];
            idx_in  = 2'd0;
         end
      end else if (slot_free) begin
         rsp_valid_in = 1'b1;
         if (job_ff.status != ST_CHAR) begin
            rsp_symbol_in = 7'd0;
            rsp_last_in   = 1'b1;
            rsp_status_in = job_ff.status;
            busy_in       = 1'b0;
         end else begin
            rsp_symbol_in = symbol_of(pos_ff, pattern_sel(cur_digit, idx_ff));
            rsp_status_in = ST_CHAR;
            // last character once this digit ends and nothing nonzero lies below
            rsp_last_in   = digit_done && !lower[2];
            if (!digit_done) begin
               idx_in = idx_ff + 2'd1;
            end else if (lower[2]) begin
               pos_in = lower[1:0];
               idx_in = 2'd0;
            end else begin
               busy_in = 1'b0;
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ src/binary_to_roman_numeral.sv @@
// Top level of the binary to Roman numeral converter.
// Converts a 12-bit unsigned value into Roman numeral ASCII characters (I V X L C D M), most
// significant first, one per output transfer, with rsp_last on the final one. Zero gives one
// transfer with status 2 and values above 3999 one with status 1, symbol 0 in both. The front
// end steps through accept, thousands, hundreds, tens and hand-off for each value (accept and
// hand-off only for zero or out of range) and queues it; the character emitter takes a queued
// value and then puts out one character per cycle while the output is not stalled, and takes
// no new value before it has put out the final result of the current one.
module binary_to_roman_numeral #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_symbol,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);
   import b2r_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   b2r_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b2r_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   b2r_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status)
   );

`ifndef ASSERT_OFF
   // Special results are single, final and carry no character
   a_special_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_CHAR) |-> rsp_last && (rsp_symbol == 7'd0))
      else $error("special result not a lone final item");

   // Characters are only the seven numeral letters
   a_legal_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CHAR) |->
         (rsp_symbol == ASCII_I) || (rsp_symbol == ASCII_V) || (rsp_symbol == ASCII_X) ||
         (rsp_symbol == ASCII_L) || (rsp_symbol == ASCII_C) || (rsp_symbol == ASCII_D) ||
         (rsp_symbol == ASCII_M))
      else $error("illegal numeral character");

   // Front end never accepts an input in the cycle after an input transfer
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front end took two items back to back");

   // A numeral is emitted without gaps once its first character is taken
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a numeral");
`endif

endmodule

@@ test/binary_to_roman_numeral_test.sv @@
// Self-checking testbench for the binary to Roman numeral converter.
`timescale 1ns / 100ps

module binary_to_roman_numeral_test;
   import b2r_pkg::*;

   typedef struct packed {
      logic [6:0] symbol;
      logic       last;
      status_type status;
   } numeral_char_type;

   // Spells each accepted value into the characters the block should return
   class numeral_checker;
      numeral_char_type expected_chars[$];
      int errors;
      int values_seen;
      int chars_checked;
      int range_count;
      int zero_count;

      function void push_char(logic [6:0] symbol, logic last, status_type status);
         numeral_char_type c;
         c.symbol = symbol;
         c.last   = last;
         c.status = status;
         expected_chars.push_back(c);
      endfunction

      function void note_value(logic [11:0] value);
         int unsigned v;
         int unsigned scale;
         int unsigned digit;
         logic [6:0] one, five, ten;
         values_seen++;
         v = value;
         if (v > MAX_VALUE) begin
            range_count++;
            push_char(7'd0, 1'b1, ST_RANGE);
            return;
         end
         if (v == 0) begin
            zero_count++;
            push_char(7'd0, 1'b1, ST_ZERO);
            return;
         end
         scale = 1000;
         for (int p = 3; p >= 0; p--) begin
            digit = (v / scale) % 10;
            scale = scale / 10;
            case (p)
               3: begin one = ASCII_M; five = 7'd0;    ten = 7'd0;    end
               2: begin one = ASCII_C; five = ASCII_D; ten = ASCII_M; end
               1: begin one = ASCII_X; five = ASCII_L; ten = ASCII_C; end
               default: begin one = ASCII_I; five = ASCII_V; ten = ASCII_X; end
            endcase
            if (digit == 9) begin
               push_char(one, 1'b0, ST_CHAR);
               push_char(ten, 1'b0, ST_CHAR);
            end else if (digit == 4) begin
               push_char(one, 1'b0, ST_CHAR);
               push_char(five, 1'b0, ST_CHAR);
            end else begin
               if (digit >= 5) push_char(five, 1'b0, ST_CHAR);
               repeat (digit % 5) push_char(one, 1'b0, ST_CHAR);
            end
         end
         expected_chars[expected_chars.size() - 1].last = 1'b1;
      endfunction

      function void check_char(logic [6:0] symbol, logic last, logic [1:0] status);
         numeral_char_type exp;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected result symbol=%h last=%b status=%0d",
                     $time, symbol, last, status);
            errors++;
            return;
         end
         exp = expected_chars.pop_front();
         chars_checked++;
         if (exp.symbol !== symbol || exp.last !== last || exp.status !== status) begin
            $display("%0t: mismatch expected symbol=%h last=%b status=%0d,",
                     $time, exp.symbol, exp.last, exp.status,
                     " actual symbol=%h last=%b status=%0d", symbol, last, status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_value = 12'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_symbol;
   logic        rsp_last;
   logic [1:0]  rsp_status;

   bit no_idle = 1'b0;
   bit hold_output = 1'b0;

   numeral_checker numerals = new();

   binary_to_roman_numeral i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status)
   );

   always #4 clock = ~clock;

   // Transfers on both channels are sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) numerals.note_value(req_value);
         if (rsp_valid && rsp_ready) numerals.check_char(rsp_symbol, rsp_last, rsp_status);
      end
   end

   // Output side: random back-pressure, plus one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_output = 1'b0;
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= 36);
      end
   end

   task automatic send_value(input logic [11:0] value);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_numerals();
      @(negedge clock);
      req_valid <= 1'b0;
      while (numerals.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 12'd0;
      if (r < 20) return 12'($urandom_range(4095, 4000));
      if (r < 35) return 12'($urandom_range(3999, 3000));
      if (r < 50) return 12'($urandom_range(99, 1));
      return 12'($urandom_range(3999, 1));
   endfunction

   initial begin
      logic [11:0] directed[$];
      directed = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7, 12'd8, 12'd9,
                   12'd10, 12'd40, 12'd49, 12'd90, 12'd400, 12'd444, 12'd900, 12'd999,
                   12'd1000, 12'd1365, 12'd2730, 12'd3888, 12'd3999, 12'd4000, 12'd4095};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_value(directed[i]);
      drain_numerals();

      for (int i = 0; i < 500; i++) begin
         if (i == 100) hold_output = 1'b1;   // output stalls while input keeps coming
         if (i == 200 || i == 400) drain_numerals();
         no_idle = (i >= 250 && i < 330);
         send_value(pick_value());
      end
      drain_numerals();
      repeat (20) @(posedge clock);

      $display("Converted %0d values (%0d out of range, %0d zero), %0d results checked",
               numerals.values_seen, numerals.range_count, numerals.zero_count,
               numerals.chars_checked);
      $display("Covered every digit pattern, longest numerals, an output hold-off and drains");
      if (numerals.errors == 0 && numerals.pending() == 0) begin
         $display("** binary_to_roman_numeral: PASSED **");
      end else begin
         $display("** binary_to_roman_numeral: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, numerals.pending());
      $display("** binary_to_roman_numeral: FAILED **");
      $finish;
   end

endmodule
